FILE: sv/msbs_pkg.sv
package msbs_pkg;

  localparam int OpW      = 1;
  localparam int ByteW    = 8;
  localparam int IdxOutW  = 4;
  localparam int OffW     = 14;
  localparam int LenOutW  = 7;
  localparam int OutDataW = 32;

  localparam logic [OpW-1:0] OP_LOAD = 1'b0;
  localparam logic [OpW-1:0] OP_SCAN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RPLY,
    ST_RD,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic shift;
    logic clr_all;
    logic clr_one;
    logic upd;
  } cell_ctl_t;

endpackage

FILE: sv/msbs_ram.sv
module msbs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/msbs_cell.sv
module msbs_cell #(
  parameter int NumSigs = 16,
  parameter int PosW    = 7,
  parameter int Idx     = 0,
  parameter int SigW    = (NumSigs > 1) ? $clog2(NumSigs) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  msbs_pkg::cell_ctl_t              ctl_i,
  input  logic [SigW-1:0]                  addr_i,
  input  logic [SigW-1:0]                  sig_i,
  input  logic [PosW-1:0]                  pos_i,
  input  logic [msbs_pkg::ByteW-1:0]       wdata_i,
  input  logic [msbs_pkg::ByteW-1:0]       byte_i,
  input  logic [msbs_pkg::ByteW-1:0]       rb_i,
  input  logic                             p_i,
  output logic [msbs_pkg::ByteW-1:0]       rb_o,
  output logic                             p_o,
  output logic                             hit_o
);

  logic [msbs_pkg::ByteW-1:0] sig_byte;
  logic [msbs_pkg::ByteW-1:0] rb_q;
  logic [NumSigs-1:0]         p_q;
  logic                       we;

  // byte Idx of every signature
  assign we = ctl_i.wr_en && (pos_i == PosW'(Idx));

  msbs_ram #(
    .Width (msbs_pkg::ByteW),
    .Depth (NumSigs),
    .AddrW (SigW)
  ) u_sig_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_i),
    .wdata_i (wdata_i),
    .re_i    (ctl_i.rd_en),
    .raddr_i (addr_i),
    .rdata_o (sig_byte)
  );

  // prefix of length Idx+1 matches ending at the newest byte
  assign hit_o = p_i && (sig_byte == byte_i);
  assign p_o   = p_q[sig_i];
  assign rb_o  = rb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q  <= '0;
      rb_q <= '0;
    end else begin
      if (ctl_i.clr_all) begin
        p_q <= '0;
      end else if (ctl_i.clr_one) begin
        p_q[sig_i] <= 1'b0;
      end else if (ctl_i.upd) begin
        p_q[sig_i] <= hit_o;
      end
      if (ctl_i.shift) begin
        rb_q <= rb_i;
      end
    end
  end

endmodule

FILE: sv/multi_signature_byte_scanner.sv
// Multi-signature byte scanner. Signatures are loaded first, one byte per
// transaction with tuser = 0 and tlast closing each one; up to NUM_SIGS of up
// to MAX_SIG_LEN bytes are kept, extra signatures and extra bytes are dropped.
// Buffer bytes then arrive with tuser = 1, and tlast on the final byte makes
// the block report, newest signature first, the first offset of an exact
// match for every signature that matched, with tlast on the last report. A
// row of MAX_SIG_LEN cells holds byte k of every signature in a small RAM
// and a partial-match bit per signature, passing it to the next cell. The
// cell RAMs have one read port, so a scanned byte walks the signatures one
// per cycle. Closing a signature while a scan is under way replays the
// newest min(bytes scanned, MAX_SIG_LEN) bytes through the cells for it.
// The report walks the slots down from the newest, skipping unmatched
// ones and reading length and offset of each match before sending it.
// No input is taken while scanning, replaying or reporting; a finished
// result waits in the output register while the next transaction is taken.
module multi_signature_byte_scanner #(
  parameter int NUM_SIGS     = 16,
  parameter int MAX_SIG_LEN  = 64,
  parameter int MAX_SCAN_LEN = 16384
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [msbs_pkg::ByteW-1:0]        s_axis_tdata,  // data_byte
  input  logic                              s_axis_tlast,  // last
  input  logic [msbs_pkg::OpW-1:0]          s_axis_tuser,  // op
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sig_index [3:0], start_offset [17:4], sig_length [24:18], zeros above
  output logic [msbs_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                              m_axis_tlast   // last_result
);

  localparam int SigW  = (NUM_SIGS > 1) ? $clog2(NUM_SIGS) : 1;
  localparam int CntW  = $clog2(NUM_SIGS + 1);
  localparam int PosW  = $clog2(MAX_SIG_LEN + 1);
  localparam int IdxW  = (MAX_SIG_LEN > 1) ? $clog2(MAX_SIG_LEN) : 1;
  localparam int SpW   = $clog2(MAX_SCAN_LEN + 1);
  localparam int OcW   = (SpW + 1 > msbs_pkg::OffW) ? SpW + 1 : msbs_pkg::OffW;
  localparam int IxcW  = (SigW > msbs_pkg::IdxOutW) ? SigW : msbs_pkg::IdxOutW;
  localparam int LncW  = (PosW > msbs_pkg::LenOutW) ? PosW : msbs_pkg::LenOutW;
  localparam int PadW  = msbs_pkg::OutDataW - msbs_pkg::IdxOutW - msbs_pkg::OffW
                         - msbs_pkg::LenOutW;

  msbs_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  sig_cnt_q, sig_cnt_d;
  logic [PosW-1:0]  load_pos_q, load_pos_d;
  logic [SpW-1:0]   scan_pos_q, scan_pos_d;
  logic [NUM_SIGS-1:0] found_q, found_d, found_rest;
  logic [CntW-1:0]  sig_ctr_q, sig_ctr_d;
  logic             cmp_v_q, cmp_v_d;
  logic [SigW-1:0]  cmp_sig_q, cmp_sig_d;
  logic             last_q, last_d;
  logic [SigW-1:0]  rp_sig_q, rp_sig_d;
  logic [PosW-1:0]  rp_ctr_q, rp_ctr_d;
  logic             rp_live_q, rp_live_d;
  logic [SigW-1:0]  rep_idx_q, rep_idx_d;

  logic                           out_valid_q, out_valid_d;
  logic [msbs_pkg::IdxOutW-1:0]   out_idx_q, out_idx_d;
  logic [msbs_pkg::OffW-1:0]      out_off_q, out_off_d;
  logic [msbs_pkg::LenOutW-1:0]   out_len_q, out_len_d;
  logic                           out_last_q, out_last_d;

  msbs_pkg::cell_ctl_t          cell_ctl;
  logic [SigW-1:0]              cell_addr;
  logic [SigW-1:0]              cell_sig;
  logic [msbs_pkg::ByteW-1:0]   cmp_byte;
  logic [msbs_pkg::ByteW-1:0]   rb_link [MAX_SIG_LEN+1];
  logic [MAX_SIG_LEN:0]         p_link;
  logic [MAX_SIG_LEN-1:0]       hit_vec;

  logic             len_we, len_re, off_re;
  logic [SigW-1:0]  len_raddr;
  logic [PosW-1:0]  len_rd, new_len, len_m1, win;
  logic [msbs_pkg::OffW-1:0] off_rd;
  logic [OcW-1:0]   off_calc;
  logic [IxcW-1:0]  rep_ext;
  logic [LncW-1:0]  len_ext;

  logic in_acc, load_ok, scan_ok, ongoing, match, out_free, end_scan;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign load_ok  = sig_cnt_q < CntW'(NUM_SIGS);
  assign scan_ok  = scan_pos_q < SpW'(MAX_SCAN_LEN);
  assign ongoing  = scan_pos_q != '0;
  assign out_free = !out_valid_q || m_axis_tready;
  assign end_scan = sig_ctr_q == CntW'(NUM_SIGS);

  assign new_len  = (load_pos_q < PosW'(MAX_SIG_LEN)) ? load_pos_q + PosW'(1) : load_pos_q;
  assign win      = (32'(scan_pos_q) >= 32'(MAX_SIG_LEN)) ? PosW'(MAX_SIG_LEN)
                                                          : PosW'(scan_pos_q);
  assign len_m1   = len_rd - PosW'(1);
  assign off_calc = OcW'(scan_pos_q) + OcW'(1) - OcW'(len_rd);
  assign rep_ext  = IxcW'(rep_idx_q);
  assign len_ext  = LncW'(len_rd);

  always_comb begin
    found_rest             = found_q;
    found_rest[rep_idx_q]  = 1'b0;
  end

  assign match = (state_q == msbs_pkg::ST_SCAN) && cmp_v_q
              && (CntW'(cmp_sig_q) < sig_cnt_q) && !found_q[cmp_sig_q]
              && (len_rd != '0) && hit_vec[len_m1[IdxW-1:0]];

  // cell row
  assign rb_link[0] = s_axis_tdata;
  assign p_link[0]  = 1'b1;

  for (genvar j = 0; j < MAX_SIG_LEN; j++) begin : g_cell
    msbs_cell #(
      .NumSigs (NUM_SIGS),
      .PosW    (PosW),
      .Idx     (j),
      .SigW    (SigW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .addr_i  (cell_addr),
      .sig_i   (cell_sig),
      .pos_i   (load_pos_q),
      .wdata_i (s_axis_tdata),
      .byte_i  (cmp_byte),
      .rb_i    (rb_link[j]),
      .p_i     (p_link[j]),
      .rb_o    (rb_link[j+1]),
      .p_o     (p_link[j+1]),
      .hit_o   (hit_vec[j])
    );
  end

  msbs_ram #(
    .Width (PosW),
    .Depth (NUM_SIGS),
    .AddrW (SigW)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (sig_cnt_q[SigW-1:0]),
    .wdata_i (new_len),
    .re_i    (len_re),
    .raddr_i (len_raddr),
    .rdata_o (len_rd)
  );

  msbs_ram #(
    .Width (msbs_pkg::OffW),
    .Depth (NUM_SIGS),
    .AddrW (SigW)
  ) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (match),
    .waddr_i (cmp_sig_q),
    .wdata_i (off_calc[msbs_pkg::OffW-1:0]),
    .re_i    (off_re),
    .raddr_i (rep_idx_q),
    .rdata_o (off_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == msbs_pkg::OP_LOAD) begin
            if (load_ok && s_axis_tlast && ongoing) begin
              state_d = msbs_pkg::ST_RPLY;
            end
          end else if (scan_ok) begin
            state_d = msbs_pkg::ST_SCAN;
          end else if (s_axis_tlast && (found_q != '0)) begin
            state_d = msbs_pkg::ST_RD;
          end
        end
      end
      msbs_pkg::ST_SCAN: begin
        if (end_scan) begin
          state_d = (last_q && (found_d != '0)) ? msbs_pkg::ST_RD : msbs_pkg::ST_IDLE;
        end
      end
      msbs_pkg::ST_RPLY: begin
        if (rp_live_q && (rp_ctr_q == PosW'(1))) begin
          state_d = msbs_pkg::ST_IDLE;
        end
      end
      msbs_pkg::ST_RD: begin
        if (found_q[rep_idx_q]) begin
          state_d = msbs_pkg::ST_SEND;
        end
      end
      msbs_pkg::ST_SEND: begin
        if (out_free) begin
          state_d = (found_rest == '0) ? msbs_pkg::ST_IDLE : msbs_pkg::ST_RD;
        end
      end
      default: state_d = msbs_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    sig_cnt_d   = sig_cnt_q;
    load_pos_d  = load_pos_q;
    scan_pos_d  = scan_pos_q;
    found_d     = found_q;
    sig_ctr_d   = sig_ctr_q;
    cmp_v_d     = 1'b0;
    cmp_sig_d   = cmp_sig_q;
    last_d      = last_q;
    rp_sig_d    = rp_sig_q;
    rp_ctr_d    = rp_ctr_q;
    rp_live_d   = rp_live_q;
    rep_idx_d   = rep_idx_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_idx_d   = out_idx_q;
    out_off_d   = out_off_q;
    out_len_d   = out_len_q;
    out_last_d  = out_last_q;
    cell_ctl    = '0;
    cell_addr   = sig_cnt_q[SigW-1:0];
    cell_sig    = cmp_sig_q;
    cmp_byte    = rb_link[1];
    len_we      = 1'b0;
    len_re      = 1'b0;
    len_raddr   = sig_ctr_q[SigW-1:0];
    off_re      = 1'b0;
    s_axis_tready = state_q == msbs_pkg::ST_IDLE;

    unique case (state_q)
      msbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == msbs_pkg::OP_LOAD) begin
            if (load_ok) begin
              if (load_pos_q < PosW'(MAX_SIG_LEN)) begin
                cell_ctl.wr_en = 1'b1;
                load_pos_d     = load_pos_q + PosW'(1);
              end
              if (s_axis_tlast) begin
                len_we     = 1'b1;
                sig_cnt_d  = sig_cnt_q + CntW'(1);
                load_pos_d = '0;
                if (ongoing) begin
                  // bring the new signature up to date with the bytes seen
                  cell_ctl.clr_one = 1'b1;
                  cell_sig         = sig_cnt_q[SigW-1:0];
                  rp_sig_d         = sig_cnt_q[SigW-1:0];
                  rp_ctr_d         = win;
                  rp_live_d        = 1'b0;
                end
              end
            end
          end else if (scan_ok) begin
            cell_ctl.shift = 1'b1;
            last_d         = s_axis_tlast;
            sig_ctr_d      = '0;
          end else if (s_axis_tlast) begin
            cell_ctl.clr_all = 1'b1;
            scan_pos_d       = '0;
            rep_idx_d        = SigW'(NUM_SIGS - 1);
          end
        end
      end
      msbs_pkg::ST_SCAN: begin
        if (!end_scan) begin
          cell_ctl.rd_en = 1'b1;
          cell_addr      = sig_ctr_q[SigW-1:0];
          len_re         = 1'b1;
          sig_ctr_d      = sig_ctr_q + CntW'(1);
          cmp_v_d        = 1'b1;
          cmp_sig_d      = sig_ctr_q[SigW-1:0];
        end
        cell_ctl.upd = cmp_v_q;
        if (match) begin
          found_d[cmp_sig_q] = 1'b1;
        end
        if (end_scan) begin
          scan_pos_d = scan_pos_q + SpW'(1);
          if (last_q) begin
            cell_ctl.clr_all = 1'b1;
            scan_pos_d       = '0;
            rep_idx_d        = SigW'(NUM_SIGS - 1);
          end
        end
      end
      msbs_pkg::ST_RPLY: begin
        cell_ctl.rd_en = 1'b1;
        cell_addr      = rp_sig_q;
        cell_sig       = rp_sig_q;
        cmp_byte       = rb_link[rp_ctr_q];
        rp_live_d      = 1'b1;
        if (rp_live_q) begin
          cell_ctl.upd = 1'b1;
          rp_ctr_d     = rp_ctr_q - PosW'(1);
        end
      end
      msbs_pkg::ST_RD: begin
        if (found_q[rep_idx_q]) begin
          len_re    = 1'b1;
          len_raddr = rep_idx_q;
          off_re    = 1'b1;
        end else begin
          rep_idx_d = rep_idx_q - SigW'(1);
        end
      end
      msbs_pkg::ST_SEND: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_idx_d   = rep_ext[msbs_pkg::IdxOutW-1:0];
          out_off_d   = off_rd;
          out_len_d   = len_ext[msbs_pkg::LenOutW-1:0];
          out_last_d  = found_rest == '0;
          found_d     = found_rest;
          rep_idx_d   = rep_idx_q - SigW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msbs_pkg::ST_IDLE;
      sig_cnt_q   <= '0;
      load_pos_q  <= '0;
      scan_pos_q  <= '0;
      found_q     <= '0;
      sig_ctr_q   <= '0;
      cmp_v_q     <= 1'b0;
      cmp_sig_q   <= '0;
      last_q      <= 1'b0;
      rp_sig_q    <= '0;
      rp_ctr_q    <= '0;
      rp_live_q   <= 1'b0;
      rep_idx_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sig_cnt_q   <= sig_cnt_d;
      load_pos_q  <= load_pos_d;
      scan_pos_q  <= scan_pos_d;
      found_q     <= found_d;
      sig_ctr_q   <= sig_ctr_d;
      cmp_v_q     <= cmp_v_d;
      cmp_sig_q   <= cmp_sig_d;
      last_q      <= last_d;
      rp_sig_q    <= rp_sig_d;
      rp_ctr_q    <= rp_ctr_d;
      rp_live_q   <= rp_live_d;
      rep_idx_q   <= rep_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_idx_q  <= out_idx_d;
    out_off_q  <= out_off_d;
    out_len_q  <= out_len_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, out_len_q, out_off_q, out_idx_q};

  a_send_has_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msbs_pkg::ST_SEND |-> found_q[rep_idx_q])
    else $error("report slot without a recorded match");

  a_report_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msbs_pkg::ST_RD |-> found_q != '0)
    else $error("report walk with no matches left");

  a_load_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sig_cnt_q <= CntW'(NUM_SIGS)) && (load_pos_q <= PosW'(MAX_SIG_LEN)))
    else $error("signature count or load position out of range");

  a_replay_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msbs_pkg::ST_RPLY |-> rp_ctr_q != '0)
    else $error("replay running with nothing to replay");

endmodule

FILE: bench/multi_signature_byte_scanner_test.sv
`timescale 1ns / 100ps

module multi_signature_byte_scanner_test;
  import msbs_pkg::*;

  localparam int NumSigs    = 16;
  localparam int MaxSigLen  = 64;
  localparam int MaxScanLen = 16384;
  localparam int IdleLimit  = 3000;
  localparam int NumDir     = 22;

  typedef struct packed {
    logic [3:0]  idx;
    logic [13:0] off;
    logic [6:0]  len;
    logic        lst;
  } match_t;

  typedef struct packed {
    logic       typed;
    logic [1:0] n_typed;
    logic       op;
    logic [7:0] data;
    logic       lst;
    match_t     t0;
    match_t     t1;
  } row_t;

  localparam match_t NoMatch = '0;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic [OpW-1:0]       s_axis_tuser = OP_LOAD;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tlast;

  bit                   calm_phase = 1'b0;
  int unsigned          stall_left = 0;
  int unsigned          err_count = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          item_count = 0;

  // scanner state as predicted
  logic [7:0]           sig_store [NumSigs][MaxSigLen];
  int                   sig_lens [NumSigs];
  int                   sigs_closed = 0;
  int                   fill_pos = 0;
  logic [7:0]           window [MaxSigLen];
  int                   scan_pos = 0;
  bit                   hit_flag [NumSigs];
  logic [13:0]          hit_off [NumSigs];

  match_t               step_matches [$];
  match_t               pending_matches [$];

  row_t dir_rows [NumDir] = '{
    '{1'b1, 2'd0, OP_SCAN, 8'h00, 1'b1, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_LOAD, 8'hFF, 1'b1, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_LOAD, 8'h00, 1'b0, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_LOAD, 8'h00, 1'b1, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_SCAN, 8'h00, 1'b1, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_SCAN, 8'hFF, 1'b0, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_SCAN, 8'h00, 1'b0, NoMatch, NoMatch},
    '{1'b1, 2'd2, OP_SCAN, 8'h00, 1'b1, '{4'd1, 14'd1, 7'd2, 1'b0},
      '{4'd0, 14'd0, 7'd1, 1'b1}},
    '{1'b1, 2'd0, OP_LOAD, 8'hAA, 1'b0, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_SCAN, 8'hAA, 1'b0, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_SCAN, 8'h55, 1'b1, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_SCAN, 8'hAA, 1'b0, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_LOAD, 8'h55, 1'b1, NoMatch, NoMatch},
    '{1'b0, 2'd0, OP_SCAN, 8'h55, 1'b0, NoMatch, NoMatch},
    '{1'b0, 2'd0, OP_SCAN, 8'hFF, 1'b1, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_LOAD, 8'h80, 1'b0, NoMatch, NoMatch},
    '{1'b1, 2'd0, OP_LOAD, 8'h7F, 1'b1, NoMatch, NoMatch},
    '{1'b0, 2'd0, OP_SCAN, 8'h7F, 1'b0, NoMatch, NoMatch},
    '{1'b0, 2'd0, OP_SCAN, 8'h80, 1'b0, NoMatch, NoMatch},
    '{1'b0, 2'd0, OP_SCAN, 8'h7F, 1'b1, NoMatch, NoMatch},
    '{1'b0, 2'd0, OP_SCAN, 8'hFE, 1'b0, NoMatch, NoMatch},
    '{1'b0, 2'd0, OP_SCAN, 8'h01, 1'b1, NoMatch, NoMatch}
  };

  multi_signature_byte_scanner #(
    .NUM_SIGS     (NumSigs),
    .MAX_SIG_LEN  (MaxSigLen),
    .MAX_SCAN_LEN (MaxScanLen)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    err_count++;
  endtask

  // one transaction through the scanner state; results land in step_matches
  task automatic predict_matches(input logic op, input logic [7:0] b, input logic lst);
    int  s;
    int  k;
    int  sl;
    int  lowest;
    bit  hit;
    step_matches.delete();
    if (op == OP_LOAD) begin
      if (sigs_closed < NumSigs) begin
        if (fill_pos < MaxSigLen) begin
          sig_store[sigs_closed][fill_pos] = b;
          fill_pos++;
        end
        if (lst) begin
          sig_lens[sigs_closed] = fill_pos;
          sigs_closed++;
          fill_pos = 0;
        end
      end
    end else begin
      if (scan_pos < MaxScanLen) begin
        for (k = MaxSigLen - 1; k > 0; k--) window[k] = window[k - 1];
        window[0] = b;
        for (s = 0; s < sigs_closed; s++) begin
          sl = sig_lens[s];
          if (!hit_flag[s] && sl != 0 && scan_pos + 1 >= sl) begin
            hit = 1'b1;
            for (k = 0; k < sl; k++)
              if (sig_store[s][sl - 1 - k] != window[k]) hit = 1'b0;
            if (hit) begin
              hit_flag[s] = 1'b1;
              hit_off[s] = 14'(scan_pos + 1 - sl);
            end
          end
        end
        scan_pos++;
      end
      if (lst) begin
        lowest = -1;
        for (s = 0; s < sigs_closed && lowest < 0; s++)
          if (hit_flag[s]) lowest = s;
        for (s = sigs_closed - 1; s >= 0; s--)
          if (hit_flag[s])
            step_matches.push_back('{idx: 4'(s), off: hit_off[s],
                                     len: 7'(sig_lens[s]), lst: (s == lowest)});
        for (k = 0; k < MaxSigLen; k++) window[k] = 8'h00;
        for (s = 0; s < NumSigs; s++) hit_flag[s] = 1'b0;
        scan_pos = 0;
      end
    end
  endtask

  // n_typed < 0: expectations come from the predictor
  task automatic send_item(input logic op, input logic [7:0] b, input logic lst,
                           input int n_typed, input match_t t0, input match_t t1);
    int unsigned gap;
    gap = calm_phase ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    if (!(op == OP_LOAD && sigs_closed >= NumSigs)) item_count++;
    predict_matches(op, b, lst);
    if (n_typed < 0) begin
      foreach (step_matches[i]) pending_matches.push_back(step_matches[i]);
    end else begin
      if (n_typed > 0) pending_matches.push_back(t0);
      if (n_typed > 1) pending_matches.push_back(t1);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_matches.size() != 0) @(negedge clk_i);
  endtask

  task automatic scan_episode(input bit finish);
    logic [7:0] scan_bytes [$];
    logic [7:0] alpha [4];
    int         n;
    int         k;
    int         s;
    int         at;
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
    for (k = 0; k < 4; k++) alpha[k] = 8'($urandom);
    for (k = 0; k < n; k++)
      scan_bytes.push_back(($urandom_range(0, 2) != 0) ? alpha[$urandom_range(0, 3)]
                                                       : 8'($urandom));
    if (sigs_closed != 0 && $urandom_range(0, 3) != 0) begin
      s = $urandom_range(0, sigs_closed - 1);
      while (scan_bytes.size() < sig_lens[s]) scan_bytes.push_back(8'($urandom));
      at = $urandom_range(0, scan_bytes.size() - sig_lens[s]);
      for (k = 0; k < sig_lens[s]; k++) scan_bytes[at + k] = sig_store[s][k];
    end
    for (k = 0; k < scan_bytes.size(); k++)
      send_item(OP_SCAN, scan_bytes[k], finish && (k == scan_bytes.size() - 1), -1,
                NoMatch, NoMatch);
  endtask

  // a signature, sometimes with a scan cutting into it while still open
  task automatic load_episode();
    logic [7:0] body [$];
    logic [7:0] alpha [4];
    int         n;
    int         k;
    int         cut;
    if (sigs_closed == 6) n = $urandom_range(65, 72);
    else if ($urandom_range(0, 5) == 0) n = $urandom_range(7, 40);
    else n = $urandom_range(1, 6);
    for (k = 0; k < 4; k++) alpha[k] = 8'($urandom);
    for (k = 0; k < n; k++)
      body.push_back(($urandom_range(0, 2) != 0) ? alpha[$urandom_range(0, 3)]
                                                 : 8'($urandom));
    cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
    for (k = 0; k < n; k++) begin
      if (k == cut) scan_episode($urandom_range(0, 1));
      send_item(OP_LOAD, body[k], k == n - 1, -1, NoMatch, NoMatch);
    end
  endtask

  always @(negedge clk_i) begin : rx_pace
    int unsigned g;
    if (calm_phase) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      g = pick_gap();
      m_axis_tready <= (g == 0);
      stall_left = (g == 0) ? 0 : g - 1;
    end
  end

  always @(posedge clk_i) begin : out_check
    match_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_matches.size() == 0) begin
        report_mismatch("transaction with nothing expected", m_axis_tdata, 0);
      end else begin
        want = pending_matches.pop_front();
        if (m_axis_tdata[3:0] != want.idx)
          report_mismatch("sig_index", m_axis_tdata[3:0], want.idx);
        if (m_axis_tdata[17:4] != want.off)
          report_mismatch("start_offset", m_axis_tdata[17:4], want.off);
        if (m_axis_tdata[24:18] != want.len)
          report_mismatch("sig_length", m_axis_tdata[24:18], want.len);
        if (m_axis_tdata[OutDataW-1:25] != '0)
          report_mismatch("tdata padding", m_axis_tdata[OutDataW-1:25], 0);
        if (m_axis_tlast != want.lst)
          report_mismatch("tlast", m_axis_tlast, want.lst);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int         r;
    int         big;
    int         at;
    int         k;
    logic [7:0] b;
    for (k = 0; k < MaxSigLen; k++) window[k] = 8'h00;
    for (k = 0; k < NumSigs; k++) begin
      sig_lens[k] = 0;
      hit_flag[k] = 1'b0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (r = 0; r < NumDir; r++)
      send_item(dir_rows[r].op, dir_rows[r].data, dir_rows[r].lst,
                dir_rows[r].typed ? int'(dir_rows[r].n_typed) : -1,
                dir_rows[r].t0, dir_rows[r].t1);

    while (item_count < 310) begin
      calm_phase <= ($urandom_range(0, 4) == 0);
      if (sigs_closed < NumSigs && ($urandom_range(0, 1) == 0 || item_count > 160))
        load_episode();
      scan_episode(1'b1);
      if ($urandom_range(0, 5) == 0) wait_drained();
    end
    while (sigs_closed < NumSigs) begin
      load_episode();
      scan_episode(1'b1);
    end
    // table full: this signature must be dropped
    load_episode();
    scan_episode(1'b1);
    wait_drained();

    // buffer past the scan limit, longest signature ending on the final counted byte
    big = 0;
    for (k = 1; k < sigs_closed; k++)
      if (sig_lens[k] > sig_lens[big]) big = k;
    at = MaxScanLen - sig_lens[big];
    for (k = 0; k < MaxScanLen + 8; k++) begin
      b = (k >= at && k < at + sig_lens[big]) ? sig_store[big][k - at] : 8'($urandom);
      send_item(OP_SCAN, b, k == MaxScanLen + 7, -1, NoMatch, NoMatch);
    end
    scan_episode(1'b1);

    s_axis_tvalid <= 1'b0;
    wait_drained();
    repeat (100) @(negedge clk_i);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
